/* rtl/bmca_pkg.sv */
`timescale 1ns / 1ps
package bmca_pkg;

  localparam int TIME_W     = 48;
  localparam int PRICE_W    = 48;
  localparam int SUM_W      = 56;
  localparam int CNT_W      = 16;
  localparam int STEP_W     = 27;
  localparam int HW_W       = 6;
  localparam int IDX_W      = 32;
  localparam int RING_DEPTH = 128;
  localparam int RING_AW    = 7;
  localparam int MAX_OUT    = 64;
  localparam int NOUT_W     = 7;
  localparam int ACC_W      = 55;
  localparam int ACNT_W     = 7;
  localparam int D_W        = 7;
  localparam int DCNT_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HWA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HWB  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HWC  = 2'd3;

  localparam logic [STEP_W-1:0] STEP_RST = 27'd30000;
  localparam logic [HW_W-1:0]   HWA_RST  = 6'd10;
  localparam logic [HW_W-1:0]   HWB_RST  = 6'd30;
  localparam logic [HW_W-1:0]   HWC_RST  = 6'd63;

  localparam logic [1:0] DSEL_MEAN = 2'd0;
  localparam logic [1:0] DSEL_A    = 2'd1;
  localparam logic [1:0] DSEL_B    = 2'd2;
  localparam logic [1:0] DSEL_C    = 2'd3;

  typedef struct packed {
    logic       tick_load;
    logic       sum_tick;
    logic       mean_direct;
    logic       div_start;
    logic [1:0] div_sel;
    logic       write_bkt;
    logic       sweep_init;
    logic       sweep_issue;
    logic       out_load;
    logic       series_clear;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic count_zero;
    logic last;
    logic div_done;
    logic div_busy;
    logic emit_more;
    logic d_last;
    logic out_free;
  } stat_t;

endpackage

/* rtl/bmca_ram.sv */
`timescale 1ns / 1ps
module bmca_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bmca_div.sv */
`timescale 1ns / 1ps
module bmca_div
  import bmca_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic [DCNT_W-1:0] cnt;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign trial = {rem, quotient[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[SUM_W-2:0], ge};
      rem      <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

endmodule

/* rtl/bmca_ctrl.sv */
`timescale 1ns / 1ps
module bmca_ctrl
  import bmca_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DIVM  = 4'd2;
  localparam logic [3:0] S_WRITE = 4'd3;
  localparam logic [3:0] S_EMIT  = 4'd4;
  localparam logic [3:0] S_SWEEP = 4'd5;
  localparam logic [3:0] S_DRAIN = 4'd6;
  localparam logic [3:0] S_SUMS  = 4'd7;
  localparam logic [3:0] S_DIVA  = 4'd8;
  localparam logic [3:0] S_DIVB  = 4'd9;
  localparam logic [3:0] S_DIVC  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.tick_load = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.close) begin
          if (stat.count_zero) begin
            cmd.mean_direct = 1'b1;
            state_next      = S_WRITE;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_MEAN;
            state_next    = S_DIVM;
          end
        end else begin
          cmd.sum_tick = 1'b1;
          state_next   = S_EMIT;
        end
      end
      S_DIVM: begin
        if (stat.div_done) state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.write_bkt = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        if (stat.emit_more) begin
          cmd.sweep_init = 1'b1;
          state_next     = S_SWEEP;
        end else begin
          cmd.series_clear = stat.last;
          state_next       = S_IDLE;
        end
      end
      S_SWEEP: begin
        cmd.sweep_issue = 1'b1;
        if (stat.d_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_SUMS;
      end
      S_SUMS: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_A;
        state_next    = S_DIVA;
      end
      S_DIVA: begin
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_B;
          state_next    = S_DIVB;
        end
      end
      S_DIVB: begin
        if (stat.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_C;
          state_next    = S_DIVC;
        end
      end
      S_DIVC: begin
        if (stat.div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_EMIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/bmca_dp.sv */
`timescale 1ns / 1ps
module bmca_dp
  import bmca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [TIME_W-1:0]     tick_time,
  input  logic [PRICE_W-1:0]    tick_price,
  input  logic                  end_of_series,
  input  logic                  out_stall,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  out_valid,
  output logic [TIME_W-1:0]     bucket_time,
  output logic [PRICE_W-1:0]    bucket_mean,
  output logic [PRICE_W-1:0]    average_a,
  output logic [PRICE_W-1:0]    average_b,
  output logic [PRICE_W-1:0]    average_c,
  output logic                  last_of_run
);

  logic [STEP_W-1:0]  step;
  logic [HW_W-1:0]    hw_a, hw_b, hw_c;
  logic [STEP_W-1:0]  step_eff;
  logic [HW_W-1:0]    hmax;

  logic [TIME_W-1:0]  t_r;
  logic [PRICE_W-1:0] p_r;
  logic               last_r;

  logic               started;
  logic [TIME_W-1:0]  start;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   bi, ei;
  logic [NOUT_W-1:0]  n;

  logic [SUM_W:0]     sum_p;
  logic               sum_ok;
  logic [TIME_W:0]    bucket_end;
  logic [IDX_W-1:0]   pending;
  logic [IDX_W-1:0]   hmax_x;
  logic               is_final;

  logic [PRICE_W-1:0] mean_new;
  logic [TIME_W-1:0]  time_new;
  logic [PRICE_W-1:0] mean_rd, time_rd;

  logic signed [D_W-1:0] d;
  logic [D_W-1:0]        dmag_w;
  logic [HW_W-1:0]       dmag;
  logic                  d_vld;
  logic [RING_AW-1:0]    rd_addr;
  logic                  pipe_on, pipe_vld;
  logic [HW_W-1:0]       pipe_mag;
  logic [ACC_W-1:0]      sa, sb, sc;
  logic [ACNT_W-1:0]     ca, cb, cc;
  logic [PRICE_W-1:0]    cur_mean;
  logic                  final_r;
  logic [PRICE_W-1:0]    avg_a, avg_b, avg_c;

  logic [1:0]         sel_r;
  logic [SUM_W-1:0]   div_num;
  logic [CNT_W-1:0]   div_den;
  logic [SUM_W-1:0]   quo;
  logic               div_busy, div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_RST;
      hw_a <= HWA_RST;
      hw_b <= HWB_RST;
      hw_c <= HWC_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_STEP: step <= cfg_data;
        CFG_HWA:  hw_a <= cfg_data[HW_W-1:0];
        CFG_HWB:  hw_b <= cfg_data[HW_W-1:0];
        CFG_HWC:  hw_c <= cfg_data[HW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hmax = hw_a;
    if (hw_b > hmax) hmax = hw_b;
    if (hw_c > hmax) hmax = hw_c;
  end

  assign step_eff   = (step == '0) ? STEP_W'(1) : step;
  assign sum_p      = {1'b0, sum} + {{(SUM_W + 1 - PRICE_W){1'b0}}, p_r};
  assign sum_ok     = (count != {CNT_W{1'b1}}) && !sum_p[SUM_W];
  assign bucket_end = {1'b0, start} + {{(TIME_W + 1 - STEP_W){1'b0}}, step_eff};
  assign pending    = bi - ei;
  assign hmax_x     = {{(IDX_W - HW_W){1'b0}}, hmax};
  assign time_new   = start + {{(TIME_W - STEP_W + 1){1'b0}}, step_eff[STEP_W-1:1]};

  assign is_final = (n + 1'b1 == NOUT_W'(MAX_OUT)) ||
                    (last_r ? (pending == IDX_W'(1)) : (pending - 1'b1 <= hmax_x));

  assign stat.close      = last_r || ({1'b0, t_r} > bucket_end);
  assign stat.count_zero = count == '0;
  assign stat.last       = last_r;
  assign stat.div_done   = div_done;
  assign stat.div_busy   = div_busy;
  assign stat.emit_more  = (n != NOUT_W'(MAX_OUT)) &&
                           (last_r ? (pending != '0) : (pending > hmax_x));
  assign stat.d_last     = d == $signed({1'b0, hmax});
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.tick_load) begin
      t_r    <= tick_time;
      p_r    <= tick_price;
      last_r <= end_of_series;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      start   <= '0;
      sum     <= '0;
      count   <= '0;
      bi      <= '0;
      ei      <= '0;
      n       <= '0;
    end else begin
      if (cmd.tick_load) begin
        n <= '0;
        if (!started) begin
          started <= 1'b1;
          start   <= tick_time;
          sum     <= '0;
          count   <= '0;
        end
      end
      if (cmd.sum_tick && sum_ok) begin
        sum   <= sum_p[SUM_W-1:0];
        count <= count + 1'b1;
      end
      if (cmd.write_bkt) begin
        bi    <= bi + 1'b1;
        start <= bucket_end[TIME_W-1:0];
        sum   <= '0;
        count <= '0;
      end
      if (cmd.out_load) begin
        ei <= ei + 1'b1;
        n  <= n + 1'b1;
      end
      if (cmd.series_clear) begin
        started <= 1'b0;
        start   <= '0;
        sum     <= '0;
        count   <= '0;
        bi      <= '0;
        ei      <= '0;
      end
    end
  end

  bmca_ram #(.WIDTH(PRICE_W), .DEPTH(RING_DEPTH)) u_mean_ring (
    .clk   (clk),
    .we    (cmd.write_bkt),
    .waddr (bi[RING_AW-1:0]),
    .wdata (mean_new),
    .raddr (rd_addr),
    .rdata (mean_rd)
  );

  bmca_ram #(.WIDTH(TIME_W), .DEPTH(RING_DEPTH)) u_time_ring (
    .clk   (clk),
    .we    (cmd.write_bkt),
    .waddr (bi[RING_AW-1:0]),
    .wdata (time_new),
    .raddr (ei[RING_AW-1:0]),
    .rdata (time_rd)
  );

  // window offset walk: one ring read per cycle, accumulated in the cycle after the read
  assign dmag_w  = d[D_W-1] ? D_W'(-d) : D_W'(d);
  assign dmag    = dmag_w[HW_W-1:0];
  assign d_vld   = d[D_W-1] ? (ei >= {{(IDX_W - HW_W){1'b0}}, dmag})
                            : ({{(IDX_W - HW_W){1'b0}}, dmag} < pending);
  assign rd_addr = ei[RING_AW-1:0] + RING_AW'(d);

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_on <= 1'b0;
    end else begin
      pipe_on <= cmd.sweep_issue;
    end
  end

  always_ff @(posedge clk) begin
    pipe_vld <= d_vld;
    pipe_mag <= dmag;
    if (cmd.sweep_init) begin
      d       <= -$signed({1'b0, hmax});
      sa      <= '0;
      sb      <= '0;
      sc      <= '0;
      ca      <= '0;
      cb      <= '0;
      cc      <= '0;
      final_r <= is_final;
    end else begin
      if (cmd.sweep_issue) d <= d + 1'b1;
      if (pipe_on && pipe_vld) begin
        if (pipe_mag <= hw_a) begin
          sa <= sa + ACC_W'(mean_rd);
          ca <= ca + 1'b1;
        end
        if (pipe_mag <= hw_b) begin
          sb <= sb + ACC_W'(mean_rd);
          cb <= cb + 1'b1;
        end
        if (pipe_mag <= hw_c) begin
          sc <= sc + ACC_W'(mean_rd);
          cc <= cc + 1'b1;
        end
        if (pipe_mag == '0) cur_mean <= mean_rd;
      end
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DSEL_A: begin
        div_num = SUM_W'(sa);
        div_den = CNT_W'(ca);
      end
      DSEL_B: begin
        div_num = SUM_W'(sb);
        div_den = CNT_W'(cb);
      end
      DSEL_C: begin
        div_num = SUM_W'(sc);
        div_den = CNT_W'(cc);
      end
      default: begin
        div_num = sum;
        div_den = count;
      end
    endcase
  end

  bmca_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) sel_r <= cmd.div_sel;
    if (cmd.mean_direct) mean_new <= p_r;
    if (div_done) begin
      case (sel_r)
        DSEL_A:  avg_a    <= quo[PRICE_W-1:0];
        DSEL_B:  avg_b    <= quo[PRICE_W-1:0];
        DSEL_C:  avg_c    <= quo[PRICE_W-1:0];
        default: mean_new <= quo[PRICE_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      bucket_time <= time_rd;
      bucket_mean <= cur_mean;
      average_a   <= avg_a;
      average_b   <= avg_b;
      average_c   <= avg_c;
      last_of_run <= final_r;
    end
  end

endmodule

/* rtl/bucket_mean_centered_averages.sv */
`timescale 1ns / 1ps
// Centered moving averages of time-bucket price means.
// Tick channel: in_valid/in_stall with tick_time, tick_price, end_of_series.
// Result channel: out_valid/out_stall with bucket_time, bucket_mean,
// average_a/b/c and last_of_run (set on the last result of a tick).
// Config channel: cfg_valid/cfg_ready, cfg_index selects bucket_step,
// half_width_a, half_width_b, half_width_c; write only while idle.
// A tick holds in_stall while it is processed and, on a bucket close, during
// the 56-step division of a non-empty bucket (an empty bucket skips it).
// Each result then takes 2*H+1 ring reads (H = largest half width), three
// divisions on the shared serial divider and a free output register.
// A tick is held off (in_stall) until all its results are in the output
// register. A stalled result stays in the output register; the next
// result waits for it, the next tick may already be accepted.
// Reset (rst, synchronous) restores register defaults and clears the
// series; ring contents are undefined and only entries of the current
// series are read.
module bucket_mean_centered_averages
  import bmca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     tick_time,
  input  logic [PRICE_W-1:0]    tick_price,
  input  logic                  end_of_series,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TIME_W-1:0]     bucket_time,
  output logic [PRICE_W-1:0]    bucket_mean,
  output logic [PRICE_W-1:0]    average_a,
  output logic [PRICE_W-1:0]    average_b,
  output logic [PRICE_W-1:0]    average_c,
  output logic                  last_of_run,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  bmca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmca_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .tick_time     (tick_time),
    .tick_price    (tick_price),
    .end_of_series (end_of_series),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .bucket_time   (bucket_time),
    .bucket_mean   (bucket_mean),
    .average_a     (average_a),
    .average_b     (average_b),
    .average_c     (average_c),
    .last_of_run   (last_of_run)
  );

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled transaction");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("out_valid rose without a load");

  a_tick_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("tick accepted without entering processing");
`endif

endmodule

/* dv/bucket_mean_centered_averages_checker.sv */
`timescale 1ns / 1ps
module bucket_mean_centered_averages_checker
  import bmca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [TIME_W-1:0]     tick_time,
  input  logic [PRICE_W-1:0]    tick_price,
  input  logic                  end_of_series,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [TIME_W-1:0]     bucket_time,
  input  logic [PRICE_W-1:0]    bucket_mean,
  input  logic [PRICE_W-1:0]    average_a,
  input  logic [PRICE_W-1:0]    average_b,
  input  logic [PRICE_W-1:0]    average_c,
  input  logic                  last_of_run,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending,
  output int                    checked
);

  typedef struct {
    logic [TIME_W-1:0]  btime;
    logic [PRICE_W-1:0] mean;
    logic [PRICE_W-1:0] avg_a;
    logic [PRICE_W-1:0] avg_b;
    logic [PRICE_W-1:0] avg_c;
    logic               last;
  } bucket_result_t;

  localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;

  bucket_result_t expected_results[$];

  logic [STEP_W-1:0]  step_q;
  logic [HW_W-1:0]    hw_q [3];
  logic [TIME_W-1:0]  b_start;
  logic [SUM_W-1:0]   b_sum;
  logic [CNT_W-1:0]   b_cnt;
  logic               started;
  logic [PRICE_W-1:0] mean_mem [RING_DEPTH];
  logic [TIME_W-1:0]  time_mem [RING_DEPTH];
  logic [IDX_W-1:0]   closed_n;
  logic [IDX_W-1:0]   emitted_n;

  function automatic logic [PRICE_W-1:0] window_avg(logic [IDX_W-1:0] e, int hw);
    longint unsigned acc;
    longint unsigned cnt;
    logic [IDX_W-1:0] ahead;
    logic [IDX_W-1:0] k;
    acc = 0;
    cnt = 0;
    ahead = closed_n - e;
    for (int d = -hw; d <= hw; d++) begin
      if (d < 0) begin
        if (e < IDX_W'(-d)) continue;
        k = e - IDX_W'(-d);
      end else begin
        if (IDX_W'(d) >= ahead) break;
        k = e + IDX_W'(d);
      end
      acc += mean_mem[k[RING_AW-1:0]];
      cnt++;
    end
    return cnt != 0 ? PRICE_W'(acc / cnt) : '0;
  endfunction

  task automatic clear_series();
    b_start = '0;
    b_sum = '0;
    b_cnt = '0;
    started = 1'b0;
    closed_n = '0;
    emitted_n = '0;
  endtask

  task automatic predict_tick(logic [TIME_W-1:0] t, logic [PRICE_W-1:0] p, logic fin);
    longint unsigned stp;
    int hmax;
    int n;
    logic [RING_AW-1:0] slot;
    bucket_result_t r;
    stp = (step_q == 0) ? 1 : step_q;
    hmax = hw_q[0];
    if (hw_q[1] > hmax) hmax = hw_q[1];
    if (hw_q[2] > hmax) hmax = hw_q[2];
    if (!started) begin
      started = 1'b1;
      b_start = t;
      b_sum = '0;
      b_cnt = '0;
    end
    if (fin || longint'(t) > longint'(b_start) + stp) begin
      slot = closed_n[RING_AW-1:0];
      mean_mem[slot] = (b_cnt != 0) ? PRICE_W'(b_sum / b_cnt) : p;
      time_mem[slot] = TIME_W'(longint'(b_start) + stp / 2);
      closed_n++;
      b_start = TIME_W'(longint'(b_start) + stp);
      b_sum = '0;
      b_cnt = '0;
    end else if (b_cnt != '1 && longint'(b_sum) + longint'(p) <= SUM_MAX) begin
      b_sum = b_sum + p;
      b_cnt++;
    end
    n = 0;
    while (n < MAX_OUT) begin
      if (fin ? (closed_n == emitted_n) : ((closed_n - emitted_n) <= hmax)) break;
      slot = emitted_n[RING_AW-1:0];
      r.btime = time_mem[slot];
      r.mean = mean_mem[slot];
      r.avg_a = window_avg(emitted_n, hw_q[0]);
      r.avg_b = window_avg(emitted_n, hw_q[1]);
      r.avg_c = window_avg(emitted_n, hw_q[2]);
      r.last = 1'b0;
      expected_results.push_back(r);
      emitted_n++;
      n++;
    end
    if (n > 0) expected_results[$].last = 1'b1;
    if (fin) clear_series();
  endtask

  always @(posedge clk) begin
    bucket_result_t exp_r;
    if (rst) begin
      step_q <= STEP_RST;
      hw_q[0] <= HWA_RST;
      hw_q[1] <= HWB_RST;
      hw_q[2] <= HWC_RST;
      clear_series();
      expected_results.delete();
      mismatches <= 0;
      checked <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("%0t: unexpected result transaction time=%h mean=%h", $realtime,
                     bucket_time, bucket_mean);
        end else begin
          exp_r = expected_results.pop_front();
          checked <= checked + 1;
          if (exp_r.btime !== bucket_time || exp_r.mean !== bucket_mean ||
              exp_r.avg_a !== average_a || exp_r.avg_b !== average_b ||
              exp_r.avg_c !== average_c || exp_r.last !== last_of_run) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("%0t: mismatch exp time=%h mean=%h a=%h b=%h c=%h last=%b",
                       $realtime, exp_r.btime, exp_r.mean, exp_r.avg_a, exp_r.avg_b,
                       exp_r.avg_c, exp_r.last);
              $display("          got time=%h mean=%h a=%h b=%h c=%h last=%b",
                       bucket_time, bucket_mean, average_a, average_b, average_c,
                       last_of_run);
            end
          end
        end
      end
      if (in_valid && !in_stall) predict_tick(tick_time, tick_price, end_of_series);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STEP: step_q <= cfg_data[STEP_W-1:0];
          CFG_HWA:  hw_q[0] <= cfg_data[HW_W-1:0];
          CFG_HWB:  hw_q[1] <= cfg_data[HW_W-1:0];
          CFG_HWC:  hw_q[2] <= cfg_data[HW_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= expected_results.size();
  end

endmodule

/* dv/bucket_mean_centered_averages_tb.sv */
`timescale 1ns / 1ps
module bucket_mean_centered_averages_tb;
  import bmca_pkg::*;

  localparam longint unsigned TIME_MAX = (64'd1 << TIME_W) - 1;
  localparam int WATCHDOG_LIMIT = 30000;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [TIME_W-1:0]     tick_time;
  logic [PRICE_W-1:0]    tick_price;
  logic                  end_of_series;
  logic                  out_valid;
  logic                  out_stall;
  logic [TIME_W-1:0]     bucket_time;
  logic [PRICE_W-1:0]    bucket_mean;
  logic [PRICE_W-1:0]    average_a;
  logic [PRICE_W-1:0]    average_b;
  logic [PRICE_W-1:0]    average_c;
  logic                  last_of_run;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int pending;
  int checked;
  int ticks_sent;
  int phases;
  int idle_cycles;
  int stall_left;
  bit no_idle;
  longint unsigned tcur;
  longint unsigned step_eff;

  bucket_mean_centered_averages u_dut (.*);

  bucket_mean_centered_averages_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall) stall_left <= no_idle ? 0 : $urandom_range(0, 11);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("** bucket_mean_centered_averages: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[47:0];
  endfunction

  function automatic logic [PRICE_W-1:0] rand_price();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return PRICE_W'($urandom_range(0, 1000));
      default: return rand48();
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending != 0);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_config(logic [STEP_W-1:0] stp, logic [HW_W-1:0] a, logic [HW_W-1:0] b,
                            logic [HW_W-1:0] c);
    wait_idle();
    write_reg(CFG_STEP, CFG_DATA_W'(stp));
    write_reg(CFG_HWA, CFG_DATA_W'(a));
    write_reg(CFG_HWB, CFG_DATA_W'(b));
    write_reg(CFG_HWC, CFG_DATA_W'(c));
    step_eff = (stp == 0) ? 1 : stp;
    phases++;
  endtask

  task automatic send_tick(longint unsigned t, logic [PRICE_W-1:0] p, logic fin);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick_time <= TIME_W'(t);
    tick_price <= p;
    end_of_series <= fin;
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
    ticks_sent++;
  endtask

  task automatic run_series(int len, bit close_it);
    longint unsigned inc;
    longint unsigned t;
    case ($urandom_range(0, 3))
      0: tcur = TIME_MAX - step_eff * 80 - $urandom_range(0, 1000);
      1: tcur = $urandom_range(0, 100);
      default: tcur = rand48() >> 1;
    endcase
    for (int i = 0; i < len; i++) begin
      t = tcur;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: inc = step_eff < 3 ? $urandom_range(0, 1) :
                               longint'($urandom) % (step_eff / 3);
        6, 7: inc = step_eff + 1 + longint'($urandom) % (2 * step_eff);
        8: inc = 0;
        default: begin
          inc = 0;
          t = tcur - (longint'($urandom) % (step_eff + 1));
        end
      endcase
      if (tcur + inc <= TIME_MAX) tcur = tcur + inc;
      if (t > TIME_MAX) t = tcur;
      if (inc != 0) t = tcur;
      send_tick(t, rand_price(), close_it && i == len - 1);
    end
  endtask

  initial begin
    logic [STEP_W-1:0] stp;
    rst = 1'b1;
    in_valid = 1'b0;
    tick_time = '0;
    tick_price = '0;
    end_of_series = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_STEP;
    cfg_data = '0;
    no_idle = 1'b0;
    ticks_sent = 0;
    phases = 0;
    step_eff = 30000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default registers, a short series
    send_tick(1000, 48'h1_0000_0000, 1'b0);
    send_tick(20000, 48'h2_0000_0000, 1'b0);
    send_tick(40000, '1, 1'b0);
    send_tick(95000, 48'h3, 1'b1);

    // zero step, narrow windows, out-of-order and empty buckets
    set_config('0, 6'd0, 6'd1, 6'd2);
    send_tick(5, '0, 1'b0);
    send_tick(5, '1, 1'b0);
    send_tick(6, 48'd1, 1'b0);
    send_tick(8, 48'd5, 1'b0);
    send_tick(2, 48'd7, 1'b0);
    send_tick(20, 48'd9, 1'b0);
    send_tick(30, 48'd11, 1'b0);
    send_tick(30, 48'd13, 1'b1);

    // single-tick series at the top of the time range
    send_tick(TIME_MAX, '1, 1'b1);

    // widest step and windows, bucket start wrapping
    set_config('1, 6'd63, 6'd63, 6'd63);
    send_tick(TIME_MAX - (64'd1 << 27) - 10, 48'h8000_0000_0000, 1'b0);
    send_tick(TIME_MAX, 48'h7FFF_FFFF_FFFF, 1'b0);
    send_tick(TIME_MAX, 48'h1234_5678_9ABC, 1'b1);

    // saturate the bucket sum
    set_config(STEP_W'(1000), 6'd1, 6'd0, 6'd3);
    for (int i = 0; i < 258; i++) send_tick(64'd777, '1, 1'b0);
    send_tick(64'd5000, 48'd42, 1'b1);

    while (ticks_sent < 390) begin
      case ($urandom_range(0, 5))
        0: stp = '0;
        1: stp = 1;
        2: stp = '1;
        3: stp = STEP_W'($urandom_range(1000, 86400000));
        default: stp = STEP_W'($urandom_range(2, 1000));
      endcase
      if ($urandom_range(0, 4) == 0)
        set_config(stp, HW_W'($urandom_range(0, 63)), HW_W'($urandom_range(0, 63)),
                   HW_W'($urandom_range(0, 63)));
      else
        set_config(stp, HW_W'($urandom_range(0, 6)), HW_W'($urandom_range(0, 6)),
                   HW_W'($urandom_range(0, 8)));
      no_idle = ($urandom_range(0, 3) == 0);
      run_series($urandom_range(5, 40), $urandom_range(0, 4) != 0);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;
    wait_idle();

    $display("covered %0d ticks over %0d register settings, %0d bucket results checked",
             ticks_sent, phases, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("** bucket_mean_centered_averages: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("** bucket_mean_centered_averages: FAILED **");
    end
    $finish;
  end

endmodule
